[src/oriented_pair_rule_substituter_core_assert.svh]
// Assertion macros shared by the checker file.
// Both expect clk and arst_n in the scope of use.
`ifndef ORIENTED_PAIR_RULE_SUBSTITUTER_CORE_ASSERT_SVH
`define ORIENTED_PAIR_RULE_SUBSTITUTER_CORE_ASSERT_SVH

// same-cycle implication
`define OPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OPR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/opr_pkg.sv]
`default_nettype none

package opr_pkg;

	localparam int MAX_RULES = 256;
	localparam int SLOT_W    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W     = $clog2(MAX_RULES + 1);

	localparam int SYM_W     = 32;
	localparam int SLOTF_W   = 8;
	localparam int START_W   = 31;
	localparam int COUNT_W   = 9;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// stream payload widths
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_PAD_W  = OUT_DATA_W - SYM_W - 1;

	// request queue between front and back
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// result queue at the output
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_NODE = 2'd0,
		REQ_LOAD = 2'd1,
		REQ_READ = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_ID   = CFG_IDX_W'(0),
		CFG_RULE_COUNT = CFG_IDX_W'(1)
	} cfg_reg_t;

	typedef enum logic {
		KIND_PATH  = 1'b0,
		KIND_REPLY = 1'b1
	} kind_t;

	typedef enum logic {
		BK_DISPATCH,
		BK_SCAN
	} bk_state_t;

	typedef struct packed {
		req_t               op;
		logic [SYM_W-1:0]   node;
		logic               last;
		logic [SLOTF_W-1:0] slot;
		logic [SYM_W-1:0]   first;
		logic [SYM_W-1:0]   second;
	} req_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
		kind_t            kind;
		logic             flag;
	} out_item_t;

	typedef struct packed {
		logic [START_W-1:0] start_id;
		logic [COUNT_W-1:0] rule_count;
	} cfg_t;

endpackage

`default_nettype wire

[src/opr_ram.sv]
`default_nettype none

module opr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[src/opr_front.sv]
`default_nettype none

module opr_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [opr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic [1:0]                     s_axis_tuser,
	input  wire logic                           s_axis_tlast,
	output logic                                req_valid,
	input  wire logic                           req_ready,
	output opr_pkg::req_item_t                  req_item
);

	opr_pkg::req_item_t                in_item;
	opr_pkg::req_item_t                rq_mem [opr_pkg::RQ_DEPTH];
	logic [opr_pkg::RQ_PTR_W-1:0]      rq_wptr_q, rq_rptr_q;
	logic [opr_pkg::RQ_CNT_W-1:0]      rq_cnt_q;
	logic                              keep, push, pop;

	always_comb begin
		in_item.op     = opr_pkg::req_t'(s_axis_tuser);
		in_item.node   = s_axis_tdata[31:0];
		in_item.last   = s_axis_tlast;
		in_item.slot   = s_axis_tdata[39:32];
		in_item.first  = s_axis_tdata[71:40];
		in_item.second = s_axis_tdata[103:72];
		case (s_axis_tuser)
			opr_pkg::REQ_NODE, opr_pkg::REQ_LOAD, opr_pkg::REQ_READ: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;  // unused code: taken and dropped
			end
		endcase
	end

	assign s_axis_tready = (rq_cnt_q != opr_pkg::RQ_CNT_W'(opr_pkg::RQ_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready && keep;
	assign req_valid     = (rq_cnt_q != '0);
	assign pop           = req_valid && req_ready;
	assign req_item      = rq_mem[rq_rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wptr_q <= '0;
			rq_rptr_q <= '0;
			rq_cnt_q  <= '0;
		end else begin
			if (push) begin
				rq_wptr_q <= rq_wptr_q + 1'b1;
			end
			if (pop) begin
				rq_rptr_q <= rq_rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   rq_cnt_q <= rq_cnt_q + 1'b1;
				2'b01:   rq_cnt_q <= rq_cnt_q - 1'b1;
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rq_mem[rq_wptr_q] <= in_item;
		end
	end

endmodule

`default_nettype wire

[src/opr_back.sv]
`default_nettype none

module opr_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire opr_pkg::cfg_t                  cfg,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire opr_pkg::req_item_t             req_item,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [opr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast
);

	localparam int SW = opr_pkg::SYM_W;

	opr_pkg::bk_state_t                state_q, state_d;
	logic [SW-1:0]                     held_q, held_d, node_q, cmp_id_s1, rev_sym_q;
	logic [SW-1:0]                     neg_node, neg_held, neg_cmp_id, start_sym;
	logic [SW-1:0]                     fin_sym, fin_node, new_sym, rd_left, rd_right;
	logic                              held_vld_q, held_vld_d, last_q, rev_hit_q;
	logic                              fin, fin_fresh, fin_hit, fin_end, go_scan, issue;
	logic                              hit_set, rec_rev, ram_we, reply, fwd, rev, last_cmp;
	logic                              slot_ok, rd_flag, room, emit_old, oq_pop;
	logic [opr_pkg::SLOT_W-1:0]        raddr, waddr, cmp_slot_s1, rev_slot_q, hit_slot;
	logic [opr_pkg::CNT_W-1:0]         act_n, scan_addr_q;
	logic [2*SW-1:0]                   rd_pair, wr_pair;
	logic [opr_pkg::MAX_RULES-1:0]     used_q;
	logic [1:0]                        push_n;
	opr_pkg::out_item_t                push0, push1, end_item, old_item, oq_head;
	opr_pkg::out_item_t                oq_mem [opr_pkg::OQ_DEPTH];
	logic [opr_pkg::OQ_PTR_W-1:0]      oq_wptr_q, oq_rptr_q, oq_wptr_n1;
	logic [opr_pkg::OQ_CNT_W-1:0]      oq_cnt_q;

	// slots beyond the table size behave as absent
	always_comb begin
		if (32'(cfg.rule_count) > 32'(opr_pkg::MAX_RULES)) begin
			act_n = opr_pkg::CNT_W'(opr_pkg::MAX_RULES);
		end else begin
			act_n = opr_pkg::CNT_W'(cfg.rule_count);
		end
	end

	assign start_sym  = SW'(cfg.start_id);
	assign neg_node   = '0 - node_q;
	assign neg_held   = '0 - held_q;
	assign neg_cmp_id = '0 - cmp_id_s1;
	assign rd_left    = rd_pair[2*SW-1:SW];
	assign rd_right   = rd_pair[SW-1:0];
	assign slot_ok    = (32'(req_item.slot) < 32'(opr_pkg::MAX_RULES));
	assign waddr      = opr_pkg::SLOT_W'(req_item.slot);
	assign wr_pair    = {req_item.first, req_item.second};
	assign rd_flag    = slot_ok && used_q[waddr];
	assign room       = (oq_cnt_q <= opr_pkg::OQ_CNT_W'(opr_pkg::OQ_DEPTH - 2));
	assign fwd        = (rd_left == held_q) && (rd_right == node_q);
	assign rev        = (rd_left == neg_node) && (rd_right == neg_held);
	assign last_cmp   = (scan_addr_q >= act_n);

	opr_ram #(
		.WIDTH (2 * SW),
		.DEPTH (opr_pkg::MAX_RULES)
	) u_rules (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wr_pair),
		.raddr (raddr),
		.rdata (rd_pair)
	);

	// sequencer: one request per cycle while dispatching with room for two results, a rule scan takes one slot a cycle
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		go_scan   = 1'b0;
		issue     = 1'b0;
		raddr     = '0;
		fin       = 1'b0;
		fin_fresh = 1'b0;
		fin_hit   = 1'b0;
		fin_sym   = '0;
		fin_node  = req_item.node;
		fin_end   = req_item.last;
		hit_set   = 1'b0;
		hit_slot  = cmp_slot_s1;
		rec_rev   = 1'b0;
		ram_we    = 1'b0;
		reply     = 1'b0;
		case (state_q)
			opr_pkg::BK_DISPATCH: begin
				if (req_valid && room) begin
					req_ready = 1'b1;
					case (req_item.op)
						opr_pkg::REQ_NODE: begin
							if (!held_vld_q) begin
								fin       = 1'b1;
								fin_fresh = 1'b1;
							end else if (act_n == '0) begin
								fin = 1'b1;
							end else begin
								go_scan = 1'b1;
								issue   = 1'b1;
								state_d = opr_pkg::BK_SCAN;
							end
						end
						opr_pkg::REQ_LOAD: begin
							ram_we = slot_ok;
						end
						opr_pkg::REQ_READ: begin
							reply = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			opr_pkg::BK_SCAN: begin
				fin_node = node_q;
				fin_end  = last_q;
				if (fwd) begin
					// lowest forward hit ends the scan at once
					fin     = 1'b1;
					fin_hit = 1'b1;
					fin_sym = cmp_id_s1;
					hit_set = 1'b1;
					state_d = opr_pkg::BK_DISPATCH;
				end else if (last_cmp) begin
					fin     = 1'b1;
					state_d = opr_pkg::BK_DISPATCH;
					if (rev_hit_q) begin
						fin_hit  = 1'b1;
						fin_sym  = rev_sym_q;
						hit_set  = 1'b1;
						hit_slot = rev_slot_q;
					end else if (rev) begin
						fin_hit = 1'b1;
						fin_sym = neg_cmp_id;
						hit_set = 1'b1;
					end
				end else begin
					issue   = 1'b1;
					raddr   = scan_addr_q[opr_pkg::SLOT_W-1:0];
					rec_rev = rev && !rev_hit_q;
				end
			end
			default: begin
				state_d = opr_pkg::BK_DISPATCH;
			end
		endcase
	end

	// held symbol update and up to two results
	always_comb begin
		held_d     = held_q;
		held_vld_d = held_vld_q;
		emit_old   = 1'b0;
		new_sym    = fin_node;
		if (fin_hit) begin
			new_sym = fin_sym;
		end
		old_item = '{sym: held_q, last: 1'b0, kind: opr_pkg::KIND_PATH, flag: 1'b0};
		end_item = '{sym: new_sym, last: 1'b1, kind: opr_pkg::KIND_PATH, flag: 1'b0};
		push0    = end_item;
		push1    = end_item;
		push_n   = 2'd0;
		if (fin) begin
			emit_old   = !fin_fresh && !fin_hit;
			held_d     = new_sym;
			held_vld_d = 1'b1;
			if (emit_old) begin
				push0  = old_item;
				push_n = 2'd1;
			end
			if (fin_end) begin
				push_n     = push_n + 2'd1;
				held_d     = '0;
				held_vld_d = 1'b0;
			end
		end else if (reply) begin
			push0  = '{sym: '0, last: 1'b0, kind: opr_pkg::KIND_REPLY, flag: rd_flag};
			push_n = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= opr_pkg::BK_DISPATCH;
			held_vld_q  <= 1'b0;
			rev_hit_q   <= 1'b0;
			scan_addr_q <= '0;
			used_q      <= '0;
		end else begin
			state_q    <= state_d;
			held_vld_q <= held_vld_d;
			if (go_scan) begin
				rev_hit_q <= 1'b0;
			end else if (rec_rev) begin
				rev_hit_q <= 1'b1;
			end
			if (issue) begin
				scan_addr_q <= go_scan ? opr_pkg::CNT_W'(1) : scan_addr_q + 1'b1;
			end
			if (hit_set) begin
				used_q[hit_slot] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
		if (go_scan) begin
			node_q <= req_item.node;
			last_q <= req_item.last;
		end
		if (issue) begin
			cmp_slot_s1 <= raddr;
			cmp_id_s1   <= go_scan ? start_sym : cmp_id_s1 + 1'b1;
		end
		if (rec_rev) begin
			rev_slot_q <= cmp_slot_s1;
			rev_sym_q  <= neg_cmp_id;
		end
	end

	// result queue
	assign oq_pop     = m_axis_tvalid && m_axis_tready;
	assign oq_wptr_n1 = oq_wptr_q + 1'b1;
	assign oq_head    = oq_mem[oq_rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wptr_q <= '0;
			oq_rptr_q <= '0;
			oq_cnt_q  <= '0;
		end else begin
			oq_wptr_q <= oq_wptr_q + opr_pkg::OQ_PTR_W'(push_n);
			if (oq_pop) begin
				oq_rptr_q <= oq_rptr_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + opr_pkg::OQ_CNT_W'(push_n)
				- opr_pkg::OQ_CNT_W'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			oq_mem[oq_wptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			oq_mem[oq_wptr_n1] <= push1;
		end
	end

	assign m_axis_tvalid = (oq_cnt_q != '0);
	assign m_axis_tdata  = {{opr_pkg::OUT_PAD_W{1'b0}}, oq_head.flag, oq_head.sym};
	assign m_axis_tuser  = oq_head.kind;
	assign m_axis_tlast  = oq_head.last;

endmodule

`default_nettype wire

[src/oriented_pair_rule_substituter_core.sv]
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    requests: node, rule load, used-flag read
// m_axis    out  m_axis_tvalid/tready    path symbols and used-flag replies
// cfg       in   cfg_valid/cfg_ready     rule_start_id (0), rule_count (1)
//
// Node with a symbol held: the back end scans N = min(rule_count, 256) rule slots,
// none when N is zero; the rule RAM read port compares one slot per cycle,
// a forward hit stops the scan early.
// The input side takes requests into a 4-deep queue while it has room.
// Results wait in a 4-deep queue; a request issues only with room for two results.
// Reset clears held state and used flags at once; no clearing pass, rule RAM is unset.
`default_nettype none

module oriented_pair_rule_substituter_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// node_symbol[31:0], slot_index[39:32], pair_first[71:40], pair_second[103:72]
	input  wire logic [opr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// req_type[1:0]
	input  wire logic [1:0]                      s_axis_tuser,
	input  wire logic                            s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// out_symbol[31:0], used_flag[32], zero[39:33]
	output logic [opr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// out_kind[0]
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [opr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [opr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [opr_pkg::START_W-1:0] start_id_q;
	logic [opr_pkg::COUNT_W-1:0] rule_count_q;
	opr_pkg::cfg_t               cfg;
	opr_pkg::req_item_t          req_item;
	logic                        req_valid, req_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_id_q   <= opr_pkg::START_W'(1);
			rule_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				opr_pkg::CFG_START_ID:   start_id_q   <= cfg_data[opr_pkg::START_W-1:0];
				opr_pkg::CFG_RULE_COUNT: rule_count_q <= cfg_data[opr_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = '{start_id: start_id_q, rule_count: rule_count_q};

	opr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_item      (req_item)
	);

	opr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_item      (req_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

[src/opr_chk.sv]
`default_nettype none
`include "oriented_pair_rule_substituter_core_assert.svh"

module opr_chk (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [opr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  wire logic                            m_axis_tuser,
	input  wire logic                            m_axis_tlast,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready
);

	// a stalled result stays put
	`OPR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

	// replies carry no symbol and never close a path
	`OPR_ASSERT_IMP(a_reply_form, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == 32'd0 && !m_axis_tlast, "bad reply")

	// path symbols never carry a used flag
	`OPR_ASSERT_IMP(a_path_flag, m_axis_tvalid && !m_axis_tuser, !m_axis_tdata[32], "flag on path symbol")

	// register writes are never held off
	`OPR_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind oriented_pair_rule_substituter_core opr_chk u_opr_chk (.*);

`default_nettype wire
